FILE: rtl/rsbk_pkg.sv
// Shared constants, record and request types and sequencer state codes for the record sort unit.
package rsbk_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned KEY_W = 32;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned REC_W = KEY_W + TAG_W;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
  } rec_t;

  // Request to the record RAM: one write port, one read port.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    rec_t             wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // Load request for the output register.
  typedef struct packed {
    logic load;
    rec_t rec;
    logic fin;
    logic ovf;
  } emit_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD_I,
    S_GET_I,
    S_CMP,
    S_WB,
    S_EMIT_RD,
    S_EMIT
  } seq_state_e;

endpackage

FILE: rtl/rsbk_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module rsbk_ram #(
  parameter int unsigned DW = 8,
  parameter int unsigned AW = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rsbk_seq.sv
// Load, exchange-sort and emit sequencer working on the record RAM.
module rsbk_seq
  import rsbk_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [KEY_W-1:0] record_key_i,
  input  logic [TAG_W-1:0] record_tag_i,
  input  logic             last_record_i,
  input  logic             descending_i,
  input  logic             out_ready_i,
  input  rec_t             rdata_i,
  output mem_req_t         mem_o,
  output emit_t            emit_o
);

  seq_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             desc_q, desc_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] k_q, k_d;
  rec_t             cur_q, cur_d;
  logic             swap;
  logic             in_acc;
  logic [CNT_W-1:0] i_ext, j_ext, k_ext;

  assign i_ext  = CNT_W'(i_q);
  assign j_ext  = CNT_W'(j_q);
  assign k_ext  = CNT_W'(k_q);
  assign in_acc = in_valid_i && (state_q == S_LOAD);
  assign in_stall_o = (state_q != S_LOAD);

  // strict compare keeps equal keys where the exchange sort leaves them
  assign swap = desc_q ? (cur_q.key < rdata_i.key) : (cur_q.key > rdata_i.key);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    desc_d  = desc_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    cur_d   = cur_q;
    mem_o   = '0;
    emit_o  = '0;

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (cnt_q < CNT_W'(DEPTH)) begin
            mem_o.we        = 1'b1;
            mem_o.waddr     = cnt_q[IDX_W-1:0];
            mem_o.wdata.key = record_key_i;
            mem_o.wdata.tag = record_tag_i;
            cnt_d           = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_record_i) begin
            desc_d = descending_i;
            i_d    = '0;
            k_d    = '0;
            if (cnt_d >= CNT_W'(2)) begin
              state_d = S_RD_I;
            end else begin
              state_d = S_EMIT_RD;
            end
          end
        end
      end
      S_RD_I: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = i_q;
        state_d     = S_GET_I;
      end
      S_GET_I: begin
        cur_d       = rdata_i;
        mem_o.re    = 1'b1;
        mem_o.raddr = i_q + IDX_W'(1);
        j_d         = i_q + IDX_W'(1);
        state_d     = S_CMP;
      end
      S_CMP: begin
        if (swap) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = j_q;
          mem_o.wdata = cur_q;
          cur_d       = rdata_i;
        end
        if (j_ext + CNT_W'(1) == cnt_q) begin
          state_d = S_WB;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = j_q + IDX_W'(1);
          j_d         = j_q + IDX_W'(1);
        end
      end
      S_WB: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = i_q;
        mem_o.wdata = cur_q;
        if (i_ext + CNT_W'(2) == cnt_q) begin
          k_d     = '0;
          state_d = S_EMIT_RD;
        end else begin
          i_d     = i_q + IDX_W'(1);
          state_d = S_RD_I;
        end
      end
      S_EMIT_RD: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = k_q;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready_i) begin
          emit_o.load = 1'b1;
          emit_o.rec  = rdata_i;
          emit_o.fin  = (k_ext + CNT_W'(1) == cnt_q);
          emit_o.ovf  = emit_o.fin && ovf_q;
          if (emit_o.fin) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            mem_o.re    = 1'b1;
            mem_o.raddr = k_q + IDX_W'(1);
            k_d         = k_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      desc_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      desc_q  <= desc_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

FILE: rtl/record_sort_by_key_unit.sv
// Record sort unit top level: order register, record RAM, sequencer and output register.
//
// Records (signed 32-bit key plus 16-bit tag) are loaded one item per cycle into a
// 64-entry record RAM. The item flagged last_record_i starts an in-place exchange sort
// (outer i, inner j > i, swap only on a strict compare), ascending or descending as
// sort_descending held when that last item was taken. While sorting and emitting, the
// input is stalled. The pace of the sort is set by the single read port of the record
// RAM: record i sits in a register while record j streams past, one compare a cycle.
// Emission then delivers one result per cycle while out_stall_i is low, each read from
// the RAM through an output register so the next result is fetched while the current
// one waits. The final result carries final_result_o, and overflow_seen_o if any item
// found the store full and was dropped; the unit then returns to loading. Write
// sort_descending only while idle.
module record_sort_by_key_unit
  import rsbk_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i,
  // input items
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [KEY_W-1:0] record_key_i,
  input  logic [TAG_W-1:0] record_tag_i,
  input  logic             last_record_i,
  // result items
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [KEY_W-1:0] sorted_key_o,
  output logic [TAG_W-1:0] sorted_tag_o,
  output logic             final_result_o,
  output logic             overflow_seen_o
);

  logic     sort_descending_q;
  logic     out_valid_q, out_valid_d;
  rec_t     out_rec_q;
  logic     out_fin_q, out_ovf_q;
  logic     out_ready;
  mem_req_t mem_req;
  emit_t    emit;
  logic [REC_W-1:0] rdata_raw;
  rec_t     rdata;

  // order register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_descending_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sort_descending_q <= cfg_data_i;
    end
  end

  rsbk_ram #(
    .DW (REC_W),
    .AW (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = rec_t'(rdata_raw);

  rsbk_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .record_key_i  (record_key_i),
    .record_tag_i  (record_tag_i),
    .last_record_i (last_record_i),
    .descending_i  (sort_descending_q),
    .out_ready_i   (out_ready),
    .rdata_i       (rdata),
    .mem_o         (mem_req),
    .emit_o        (emit)
  );

  // output register: refilled when empty or when its item is taken
  assign out_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = emit.load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_rec_q <= emit.rec;
      out_fin_q <= emit.fin;
      out_ovf_q <= emit.ovf;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sorted_key_o    = out_rec_q.key;
  assign sorted_tag_o    = out_rec_q.tag;
  assign final_result_o  = out_fin_q;
  assign overflow_seen_o = out_ovf_q;

endmodule
